FILE: rtl/core/swk_pkg.sv
`timescale 1ns / 1ps
// Package for swerve wheel kinematics: widths, register indexes, CORDIC table.
// No dependencies.
package swk_pkg;

    localparam int WHEELS_DEF       = 4;
    localparam int CORDIC_STEPS_DEF = 16;
    localparam int MAX_STEPS        = 24;
    localparam int VEL_W            = 16;
    localparam int MAG_W            = 18;
    localparam int ANG_W            = 16;
    localparam int CMD_W            = 16;
    localparam int CFG_IDX_W        = 3;
    localparam int CFG_DATA_W       = 32;
    localparam int CW               = 30;   // CORDIC x/y width: 20-bit sum + 8 guard + growth
    localparam int GUARD            = 8;
    localparam logic [MAG_W-1:0] MAG_MAX = 18'h3FFFF;
    localparam logic [31:0] INV_GAIN_Q32 = 32'd2608131496;

    localparam logic [CFG_IDX_W-1:0] REG_MAX_SPEED = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CMD_MAX   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GEOM0     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GEOM3     = 3'd5;

    typedef enum logic [2:0] {
        BK_IDLE, BK_SUM, BK_CORDIC, BK_SCALE, BK_DIV, BK_EMIT
    } bk_state_t;

    typedef struct packed {
        logic signed [VEL_W-1:0] vel_x;
        logic signed [VEL_W-1:0] vel_y;
        logic signed [VEL_W-1:0] yaw_rate;
    } cmd_t;

    function automatic logic [31:0] atan_entry(input logic [4:0] i);
        logic [31:0] r;
        case (i)
            5'd0:  r = 32'd536870912;
            5'd1:  r = 32'd316933406;
            5'd2:  r = 32'd167458907;
            5'd3:  r = 32'd85004756;
            5'd4:  r = 32'd42667331;
            5'd5:  r = 32'd21354465;
            5'd6:  r = 32'd10679838;
            5'd7:  r = 32'd5340245;
            5'd8:  r = 32'd2670163;
            5'd9:  r = 32'd1335087;
            5'd10: r = 32'd667544;
            5'd11: r = 32'd333772;
            5'd12: r = 32'd166886;
            5'd13: r = 32'd83443;
            5'd14: r = 32'd41722;
            5'd15: r = 32'd20861;
            5'd16: r = 32'd10430;
            5'd17: r = 32'd5215;
            5'd18: r = 32'd2608;
            5'd19: r = 32'd1304;
            5'd20: r = 32'd652;
            5'd21: r = 32'd326;
            5'd22: r = 32'd163;
            5'd23: r = 32'd81;
            default: r = 32'd0;
        endcase
        return r;
    endfunction

endpackage

FILE: rtl/core/swk_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for commands and wheel results.
// No dependencies.
interface swk_cmd_if;
    logic                     valid;
    logic                     ready;
    logic signed [15:0]       vel_x;
    logic signed [15:0]       vel_y;
    logic signed [15:0]       yaw_rate;
    modport source (output valid, vel_x, vel_y, yaw_rate, input ready);
    modport sink   (input valid, vel_x, vel_y, yaw_rate, output ready);
endinterface

interface swk_res_if;
    logic                     valid;
    logic                     ready;
    logic [1:0]               wheel_index;
    logic signed [15:0]       steer_angle;
    logic [15:0]              drive_command;
    logic                     last_wheel;
    modport source (output valid, wheel_index, steer_angle, drive_command, last_wheel,
                    input ready);
    modport sink   (input valid, wheel_index, steer_angle, drive_command, last_wheel,
                    output ready);
endinterface

FILE: rtl/core/swk_front.sv
`timescale 1ns / 1ps
// Front end: accepts commands into a two-entry queue for the back end.
// Depends on swk_pkg, swk_if.
module swk_front (
    input  logic           clk,
    input  logic           rst_n,
    swk_cmd_if.sink        cmd,
    output logic           q_valid,
    output swk_pkg::cmd_t  q_data,
    input  logic           q_pop
);
    import swk_pkg::*;

    cmd_t       mem_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] cnt_reg;
    logic       push;

    assign cmd.ready = (cnt_reg != 2'd2);
    assign push      = cmd.valid && cmd.ready;
    assign q_valid   = (cnt_reg != 2'd0);
    assign q_data    = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= '{cmd.vel_x, cmd.vel_y, cmd.yaw_rate};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (q_pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, q_pop};
        end
    end

endmodule

FILE: rtl/core/swk_div.sv
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle: 34-bit dividend by 18-bit divisor.
// Depends on swk_pkg.
module swk_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [33:0] dividend,
    input  logic [17:0] divisor,
    output logic        done,
    output logic [33:0] quotient
);
    import swk_pkg::*;

    logic [33:0] q_reg;
    logic [18:0] rem_reg;
    logic [17:0] dvs_reg;
    logic [5:0]  cnt_reg;
    logic        busy_reg;
    logic [18:0] trial;
    logic [19:0] diff;

    assign trial    = {rem_reg[17:0], q_reg[33]};
    assign diff     = {1'b0, trial} - {2'b00, dvs_reg};
    assign done     = busy_reg && (cnt_reg == 6'd0);
    assign quotient = q_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= 6'd0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= 6'd34;
        end
        else if (busy_reg)
        begin
            if (cnt_reg == 6'd0)
            begin
                busy_reg <= 1'b0;
            end
            else
            begin
                cnt_reg <= cnt_reg - 6'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg   <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg && cnt_reg != 6'd0)
        begin
            if (!diff[19])
            begin
                rem_reg <= diff[18:0];
                q_reg   <= {q_reg[32:0], 1'b1};
            end
            else
            begin
                rem_reg <= trial;
                q_reg   <= {q_reg[32:0], 1'b0};
            end
        end
    end

endmodule

FILE: rtl/core/swk_back.sv
`timescale 1ns / 1ps
// Back end: per-wheel sum, iterative CORDIC, peak tracking, scaled drive commands.
// Depends on swk_pkg, swk_if, swk_div.
module swk_back #(
    parameter int WHEELS       = swk_pkg::WHEELS_DEF,
    parameter int CORDIC_STEPS = swk_pkg::CORDIC_STEPS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          q_valid,
    input  swk_pkg::cmd_t                 q_data,
    output logic                          q_pop,
    input  logic [swk_pkg::MAG_W-1:0]     max_speed,
    input  logic [swk_pkg::CMD_W-1:0]     cmd_max,
    input  logic [4*32-1:0]               geom,
    swk_res_if.source                     res
);
    import swk_pkg::*;

    localparam int WI_W = (WHEELS > 1) ? $clog2(WHEELS) : 1;

    bk_state_t state_reg, state_next;
    logic [WI_W-1:0]       wheel_reg;
    logic [4:0]            step_reg;
    logic [1:0]            sum_ph_reg;
    logic signed [CW-1:0]  x_reg, y_reg;
    logic [31:0]           acc_reg;
    logic                  zero_reg;
    logic signed [31:0]    prod_reg;
    logic signed [19:0]    sx_reg;
    logic [MAG_W-1:0]      mag_mem [WHEELS];
    logic [ANG_W-1:0]      ang_mem [WHEELS];
    logic [MAG_W-1:0]      peak_reg;
    logic [33:0]           num_reg;
    logic                  div_start;
    logic                  div_go_reg;
    logic                  div_done;
    logic [33:0]           quo;
    logic [MAG_W-1:0]      divisor;
    logic                  out_valid_reg;
    logic [1:0]            out_idx_reg;
    logic [ANG_W-1:0]      out_ang_reg;
    logic [CMD_W-1:0]      out_cmd_reg;
    logic                  out_last_reg;
    logic [63:0]           mag_prod_reg;
    logic                  mag_ph_reg;
    logic                  last_w;

    logic [31:0]           g_word;
    logic signed [15:0]    g_sel;
    logic signed [31:0]    prod;
    logic signed [19:0]    rnd;
    logic signed [CW-1:0]  dx, dy;
    logic [MAG_W-1:0]      mag_sat;
    logic [25:0]           mag_rnd;

    assign last_w  = (wheel_reg == WI_W'(WHEELS - 1));
    assign g_word  = geom[wheel_reg*32 +: 32];
    assign g_sel   = (sum_ph_reg == 2'd0) ? g_word[15:0] : g_word[31:16];
    assign prod    = q_data.yaw_rate * g_sel;
    assign rnd     = 20'((prod_reg + 32'sd4096) >>> 13);
    assign dx      = y_reg >>> step_reg;
    assign dy      = x_reg >>> step_reg;
    assign mag_rnd = 26'((mag_prod_reg + (64'd1 << 39)) >> 40);
    assign mag_sat = (mag_rnd > 26'(MAG_MAX)) ? MAG_MAX : mag_rnd[MAG_W-1:0];
    assign divisor = (peak_reg > max_speed) ? peak_reg
                   : ((max_speed == '0) ? MAG_W'(1) : max_speed);

    // start comes from a register on div_start so num_reg and peak_reg are settled
    swk_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_go_reg),
        .dividend (num_reg + 34'(divisor >> 1)),
        .divisor  (divisor),
        .done     (div_done),
        .quotient (quo)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE:   if (q_valid) state_next = BK_SUM;
            BK_SUM:    if (sum_ph_reg == 2'd3) state_next = BK_CORDIC;
            BK_CORDIC:
            begin
                if (zero_reg || (step_reg == 5'(CORDIC_STEPS - 1)))
                begin
                    state_next = BK_SCALE;
                end
            end
            BK_SCALE:
            begin
                if (mag_ph_reg || zero_reg)
                begin
                    state_next = last_w ? BK_DIV : BK_SUM;
                end
            end
            BK_DIV:    if (div_done) state_next = BK_EMIT;
            BK_EMIT:
            begin
                if (!out_valid_reg || res.ready)
                begin
                    state_next = last_w ? BK_IDLE : BK_DIV;
                end
            end
            default:   state_next = BK_IDLE;
        endcase
    end

    always_comb
    begin
        q_pop     = (state_reg == BK_EMIT) && last_w && (!out_valid_reg || res.ready);
        div_start = (state_reg == BK_SCALE && (mag_ph_reg || zero_reg) && last_w)
                 || (state_reg == BK_EMIT && !last_w && (!out_valid_reg || res.ready));
    end

    assign res.valid         = out_valid_reg;
    assign res.wheel_index   = out_idx_reg;
    assign res.steer_angle   = out_ang_reg;
    assign res.drive_command = out_cmd_reg;
    assign res.last_wheel    = out_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            out_valid_reg <= 1'b0;
            peak_reg      <= '0;
            div_go_reg    <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            div_go_reg <= div_start;
            if (state_reg == BK_IDLE && q_valid)
            begin
                peak_reg <= '0;
            end
            else if (state_reg == BK_SCALE && (mag_ph_reg || zero_reg))
            begin
                if (!zero_reg && mag_sat > peak_reg)
                begin
                    peak_reg <= mag_sat;
                end
            end
            if (state_reg == BK_EMIT && (!out_valid_reg || res.ready))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            BK_IDLE:
            begin
                wheel_reg  <= '0;
                sum_ph_reg <= 2'd0;
            end
            BK_SUM:
            begin
                sum_ph_reg <= sum_ph_reg + 2'd1;
                case (sum_ph_reg)
                    2'd0: prod_reg <= prod;
                    2'd1:
                    begin
                        sx_reg   <= 20'(q_data.vel_x) + rnd;
                        prod_reg <= prod;
                    end
                    2'd2: prod_reg <= 32'(20'(q_data.vel_y) + rnd);
                    default:
                    begin
                        step_reg <= 5'd0;
                        zero_reg <= (sx_reg == '0) && (prod_reg[19:0] == '0);
                        if (sx_reg < 0)
                        begin
                            x_reg   <= CW'(-sx_reg) <<< GUARD;
                            y_reg   <= CW'(-$signed(prod_reg[19:0])) <<< GUARD;
                            acc_reg <= 32'h8000_0000;
                        end
                        else
                        begin
                            x_reg   <= CW'(sx_reg) <<< GUARD;
                            y_reg   <= CW'($signed(prod_reg[19:0])) <<< GUARD;
                            acc_reg <= 32'd0;
                        end
                    end
                endcase
            end
            BK_CORDIC:
            begin
                step_reg   <= step_reg + 5'd1;
                mag_ph_reg <= 1'b0;
                if (!y_reg[CW-1])
                begin
                    x_reg   <= x_reg + dx;
                    y_reg   <= y_reg - dy;
                    acc_reg <= acc_reg + atan_entry(step_reg);
                end
                else
                begin
                    x_reg   <= x_reg - dx;
                    y_reg   <= y_reg + dy;
                    acc_reg <= acc_reg - atan_entry(step_reg);
                end
            end
            BK_SCALE:
            begin
                if (!mag_ph_reg)
                begin
                    mag_prod_reg <= x_reg[CW-1] ? 64'd0
                                  : 64'(x_reg[CW-2:0]) * 64'(INV_GAIN_Q32);
                    mag_ph_reg   <= 1'b1;
                end
                if (mag_ph_reg || zero_reg)
                begin
                    mag_mem[wheel_reg] <= zero_reg ? '0 : mag_sat;
                    ang_mem[wheel_reg] <= zero_reg ? '0 : 16'((acc_reg + 32'h8000) >> 16);
                    sum_ph_reg         <= 2'd0;
                    if (last_w)
                    begin
                        wheel_reg <= '0;
                        if (WHEELS == 1)
                        begin
                            num_reg <= 34'(cmd_max) * 34'(zero_reg ? '0 : mag_sat);
                        end
                        else
                        begin
                            num_reg <= 34'(cmd_max) * 34'(mag_mem[0]);
                        end
                    end
                    else
                    begin
                        wheel_reg <= wheel_reg + WI_W'(1);
                    end
                end
            end
            BK_EMIT:
            begin
                if (!out_valid_reg || res.ready)
                begin
                    out_idx_reg  <= 2'(wheel_reg);
                    out_ang_reg  <= ang_mem[wheel_reg];
                    out_cmd_reg  <= (quo > 34'(cmd_max)) ? cmd_max : quo[CMD_W-1:0];
                    out_last_reg <= last_w;
                    if (!last_w)
                    begin
                        wheel_reg <= wheel_reg + WI_W'(1);
                        num_reg   <= 34'(cmd_max) * 34'(mag_mem[wheel_reg + WI_W'(1)]);
                    end
                end
            end
            default: ;
        endcase
    end

endmodule

FILE: rtl/core/swerve_wheel_kinematics_top.sv
`timescale 1ns / 1ps
// Swerve wheel inverse kinematics top level.
// Depends on swk_pkg, swk_if, swk_front, swk_back, swk_div.
//
// Usage: commands (vel_x, vel_y, yaw_rate) enter on cmd; each transaction
// gives WHEELS result transactions on res, wheel 0 first, last_wheel set
// on the final one. Registers are written through cfg_we/cfg_idx/cfg_data
// while idle (the block itself does not enforce it); unknown indexes are dropped.
// Processing: after an idle state, per wheel a sum phase, CORDIC iteration
// (cut short for a zero vector) and magnitude scaling; then per wheel a
// serial division plus an output step. Throughput is set by the shared
// CORDIC loop and the bit-serial divider; the back end finishes one command
// before it starts the next.
// A two-entry queue holds further commands while the back end works.
// Reset clears the queue and the result valid flag, and loads register defaults.
// When res.ready is low the result register holds and the back end waits.
module swerve_wheel_kinematics_top #(
    parameter int WHEELS       = swk_pkg::WHEELS_DEF,
    parameter int CORDIC_STEPS = swk_pkg::CORDIC_STEPS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    swk_cmd_if.sink                           cmd,
    swk_res_if.source                         res,
    input  logic                              cfg_we,
    input  logic [swk_pkg::CFG_IDX_W-1:0]     cfg_idx,
    input  logic [swk_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import swk_pkg::*;

    logic [MAG_W-1:0] max_speed_reg;
    logic [CMD_W-1:0] cmd_max_reg;
    logic [4*32-1:0]  geom_reg;
    logic             q_valid, q_pop;
    cmd_t             q_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_speed_reg <= 18'd512;
            cmd_max_reg   <= 16'd1000;
            geom_reg      <= '0;
        end
        else if (cfg_we)
        begin
            if (cfg_idx == REG_MAX_SPEED)
            begin
                max_speed_reg <= cfg_data[MAG_W-1:0];
            end
            else if (cfg_idx == REG_CMD_MAX)
            begin
                cmd_max_reg <= cfg_data[CMD_W-1:0];
            end
            else if (cfg_idx >= REG_GEOM0 && cfg_idx <= REG_GEOM3)
            begin
                geom_reg[(cfg_idx - REG_GEOM0)*32 +: 32] <= cfg_data;
            end
        end
    end

    swk_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .q_valid (q_valid),
        .q_data  (q_data),
        .q_pop   (q_pop)
    );

    swk_back #(
        .WHEELS       (WHEELS),
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_data    (q_data),
        .q_pop     (q_pop),
        .max_speed (max_speed_reg),
        .cmd_max   (cmd_max_reg),
        .geom      (geom_reg),
        .res       (res)
    );

endmodule

FILE: rtl/core/swk_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the swerve kinematics top, bound to the top level.
// Depends on swk_pkg, swerve_wheel_kinematics_top.
module swk_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        res_valid,
    input logic        res_ready,
    input logic [1:0]  wheel_index,
    input logic [15:0] drive_command,
    input logic        last_wheel
);
    import swk_pkg::*;

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(drive_command))
        else $error("result dropped while stalled");

    a_first: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_ready && last_wheel |=> !res_valid || wheel_index == 2'd0)
        else $error("transaction after last wheel is not wheel 0");

    a_order: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_ready && !last_wheel |=>
            !res_valid || wheel_index == $past(wheel_index) + 2'd1)
        else $error("wheel order broken");

endmodule

bind swerve_wheel_kinematics_top swk_checker u_swk_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .res_valid     (res.valid),
    .res_ready     (res.ready),
    .wheel_index   (res.wheel_index),
    .drive_command (res.drive_command),
    .last_wheel    (res.last_wheel)
);

FILE: test/swerve_wheel_kinematics_top_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for swerve_wheel_kinematics_top: predicts per-wheel angle and
// drive command for each command transaction and checks every result transaction.
// Depends on swk_pkg, swk_if and the RTL of the block.
module swerve_wheel_kinematics_top_tb;
    import swk_pkg::*;

    typedef struct packed {
        logic [1:0]         wheel_index;
        logic signed [15:0] steer_angle;
        logic [15:0]        drive_command;
        logic               last_wheel;
    } wheel_res_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    swk_cmd_if cmd ();
    swk_res_if res ();

    swerve_wheel_kinematics_top dut (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .res(res),
        .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
    );

    logic [17:0] speed_limit;
    logic [15:0] cmd_limit;
    logic [31:0] geom [4];
    wheel_res_t  wheel_q [$];
    int          errors;
    int          sent;
    int          got;
    int          idle_cycles;
    int          long_stall;
    int          stall_max;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic longint floor_sh(longint v, int s);
        return v >>> s;
    endfunction

    function automatic void vector_to_polar(longint x, longint y, output logic [17:0] mag,
                                            output logic [15:0] ang);
        logic [31:0] acc;
        longint dx;
        longint dy;
        logic [63:0] m;
        acc = 32'd0;
        if (x == 0 && y == 0)
        begin
            mag = '0;
            ang = '0;
            return;
        end
        if (x < 0)
        begin
            x = -x;
            y = -y;
            acc = 32'h8000_0000;
        end
        x = x * 256;
        y = y * 256;
        for (int i = 0; i < CORDIC_STEPS_DEF; i++)
        begin
            dx = floor_sh(y, i);
            dy = floor_sh(x, i);
            if (y >= 0)
            begin
                x += dx;
                y -= dy;
                acc += atan_entry(i[4:0]);
            end
            else
            begin
                x -= dx;
                y += dy;
                acc -= atan_entry(i[4:0]);
            end
        end
        if (x < 0)
            x = 0;
        m = (64'(x) * 64'(INV_GAIN_Q32) + (64'd1 << 39)) >> 40;
        mag = (m > 64'(MAG_MAX)) ? MAG_MAX : m[17:0];
        ang = 16'((acc + 32'h8000) >> 16);
    endfunction

    function automatic void predict_wheels(logic signed [15:0] vx, logic signed [15:0] vy,
                                           logic signed [15:0] yaw);
        logic [17:0] mag [4];
        logic [15:0] ang [4];
        logic [17:0] peak;
        longint gx;
        longint gy;
        longint sx;
        longint sy;
        longint dv;
        longint c;
        wheel_res_t r;
        peak = '0;
        for (int i = 0; i < 4; i++)
        begin
            gx = longint'($signed(geom[i][15:0]));
            gy = longint'($signed(geom[i][31:16]));
            sx = longint'(vx) + floor_sh(longint'(yaw) * gx + 4096, 13);
            sy = longint'(vy) + floor_sh(longint'(yaw) * gy + 4096, 13);
            vector_to_polar(sx, sy, mag[i], ang[i]);
            if (mag[i] > peak)
                peak = mag[i];
        end
        dv = (peak > speed_limit) ? peak : speed_limit;
        if (dv == 0)
            dv = 1;
        for (int i = 0; i < 4; i++)
        begin
            c = (longint'(cmd_limit) * longint'(mag[i]) + dv / 2) / dv;
            if (c > cmd_limit)
                c = cmd_limit;
            r.wheel_index = i[1:0];
            r.steer_angle = ang[i];
            r.drive_command = c[15:0];
            r.last_wheel = (i == 3);
            wheel_q.push_back(r);
        end
    endfunction

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        case (idx)
            REG_MAX_SPEED: speed_limit = val[17:0];
            REG_CMD_MAX:   cmd_limit = val[15:0];
            default:
                if (idx >= REG_GEOM0 && idx <= REG_GEOM3)
                    geom[idx - REG_GEOM0] = val;
        endcase
    endtask

    // valid stays high after a transaction; the next call or wait_drained drives it
    task automatic send_cmd(logic [15:0] vx, logic [15:0] vy, logic [15:0] yaw, bit gaps);
        int g;
        g = 0;
        if (gaps)
            g = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 2);
        if (g > 0)
        begin
            cmd.valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        cmd.valid <= 1'b1;
        cmd.vel_x <= vx;
        cmd.vel_y <= vy;
        cmd.yaw_rate <= yaw;
        @(posedge clk);
        while (!cmd.ready)
            @(posedge clk);
        predict_wheels(vx, vy, yaw);
        sent++;
    endtask

    task automatic wait_drained();
        cmd.valid <= 1'b0;
        while (wheel_q.size() != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
    endtask

    function automatic logic [31:0] rand_geom();
        return {16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535))};
    endfunction

    task automatic test_directed();
        logic [15:0] ex [6] = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF, 16'h0001, 16'h5555};
        write_reg(REG_GEOM0, {16'sd2896, 16'sd2896});
        write_reg(REG_GEOM0 + 3'd1, {16'sd2896, -16'sd2896});
        write_reg(REG_GEOM0 + 3'd2, {-16'sd2896, -16'sd2896});
        write_reg(REG_GEOM3, {16'h8000, 16'h7FFF});
        write_reg(3'd7, 32'hFFFF_FFFF);
        write_reg(3'd6, 32'h0);
        send_cmd(16'h0, 16'h0, 16'h0, 1'b0);
        for (int i = 0; i < 6; i++)
            for (int j = 0; j < 3; j++)
                send_cmd(ex[i], ex[(i + j) % 6], ex[(i + 2 * j + 1) % 6], 1'b0);
        send_cmd(16'h0100, 16'h0, 16'h0, 1'b0);
        send_cmd(16'hFF00, 16'h0, 16'h0, 1'b0);
        wait_drained();
    endtask

    task automatic test_zero_divisor();
        write_reg(REG_MAX_SPEED, 32'd0);
        for (int i = 2; i <= 5; i++)
            write_reg(i[2:0], 32'd0);
        send_cmd(16'h0, 16'h0, 16'h1234, 1'b0);
        send_cmd(16'h0040, 16'hFFC0, 16'h0, 1'b0);
        wait_drained();
    endtask

    task automatic test_random_configs();
        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0: write_reg(REG_MAX_SPEED, 32'd1);
                1: write_reg(REG_MAX_SPEED, 32'h3FFFF);
                default: write_reg(REG_MAX_SPEED, $urandom_range(1, 4000));
            endcase
            case (ph)
                0: write_reg(REG_CMD_MAX, 32'd65535);
                1: write_reg(REG_CMD_MAX, 32'd0);
                default: write_reg(REG_CMD_MAX, $urandom_range(0, 65535));
            endcase
            for (int i = 2; i <= 5; i++)
                write_reg(i[2:0], (ph == 1) ? 32'hFFFF_FFFF : rand_geom());
            for (int n = 0; n < 38; n++)
            begin
                if (n % 3 == 0)
                    send_cmd(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                             16'($urandom_range(0, 65535)), 1'b1);
                else
                    send_cmd(16'($signed(10'($urandom_range(0, 1023)))),
                             16'($signed(10'($urandom_range(0, 1023)))),
                             16'($signed(10'($urandom_range(0, 1023)))), 1'b1);
            end
            wait_drained();
        end
    endtask

    task automatic test_backpressure();
        stall_max = 800;
        long_stall = 1;
        for (int n = 0; n < 6; n++)
            send_cmd(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                     16'($urandom_range(0, 65535)), 1'b0);
        wait_drained();
    endtask

    // result ready driver, including the long hold-off
    initial
    begin
        int g;
        res.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (long_stall == 1)
            begin
                long_stall = 2;
                res.ready <= 1'b0;
                repeat (stall_max) @(posedge clk);
            end
            g = $urandom_range(0, 19);
            if (g < 2)
            begin
                res.ready <= 1'b0;
                repeat ((g == 0) ? $urandom_range(5, 40) : $urandom_range(1, 3)) @(posedge clk);
            end
            res.ready <= 1'b1;
        end
    end

    // result checker
    always @(posedge clk)
    begin
        wheel_res_t e;
        if (rst_n && res.valid && res.ready)
        begin
            got++;
            if (wheel_q.size() == 0)
            begin
                $error("unexpected result transaction, wheel_index %0d", res.wheel_index);
                errors++;
            end
            else
            begin
                e = wheel_q.pop_front();
                if (res.wheel_index !== e.wheel_index)
                begin
                    $error("wheel_index expected %0d actual %0d", e.wheel_index,
                           res.wheel_index);
                    errors++;
                end
                if (res.steer_angle !== e.steer_angle)
                begin
                    $error("steer_angle expected %0d actual %0d", e.steer_angle,
                           res.steer_angle);
                    errors++;
                end
                if (res.drive_command !== e.drive_command)
                begin
                    $error("drive_command expected %0d actual %0d", e.drive_command,
                           res.drive_command);
                    errors++;
                end
                if (res.last_wheel !== e.last_wheel)
                begin
                    $error("last_wheel expected %0d actual %0d", e.last_wheel,
                           res.last_wheel);
                    errors++;
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if ((cmd.valid && cmd.ready) || (res.valid && res.ready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 20000)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial
    begin
        errors = 0;
        sent = 0;
        got = 0;
        idle_cycles = 0;
        long_stall = 0;
        stall_max = 0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_idx = '0;
        cfg_data = '0;
        cmd.valid = 1'b0;
        cmd.vel_x = '0;
        cmd.vel_y = '0;
        cmd.yaw_rate = '0;
        speed_limit = 18'd512;
        cmd_limit = 16'd1000;
        for (int i = 0; i < 4; i++)
            geom[i] = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_zero_divisor();
        test_random_configs();
        test_backpressure();
        $display("Covered %0d commands and %0d wheel results over extreme and random",
                 sent, got);
        $display("register settings, zero vectors, zero divisor and long output stalls.");
        if (errors == 0 && wheel_q.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

FILE: sim.f
rtl/core/swk_pkg.sv
rtl/core/swk_if.sv
rtl/core/swk_front.sv
rtl/core/swk_div.sv
rtl/core/swk_back.sv
rtl/core/swerve_wheel_kinematics_top.sv
rtl/core/swk_checker.sv
test/swerve_wheel_kinematics_top_tb.sv
